@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the shot sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, suspended while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication on every rising clk edge, suspended while arst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication, suspended while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ssf_pkg.sv @@
// Package: payload structs, configuration struct and register indexes of the shot sequencer.
package ssf_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int DURATION_W = 16;
	localparam int COUNT_W    = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_TICKS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUNK_WAIT_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_TICKS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_TICKS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DUNK_COUNT      = 3'd5;

	// register reset values
	localparam logic [DURATION_W-1:0] SPINUP_TICKS_RST    = 16'd200;
	localparam logic [DURATION_W-1:0] DUNK_WAIT_TICKS_RST = 16'd300;
	localparam logic [DURATION_W-1:0] FORWARD_TICKS_RST   = 16'd25;
	localparam logic [DURATION_W-1:0] BACK_TICKS_RST      = 16'd25;
	localparam logic [DURATION_W-1:0] DROP_TICKS_RST      = 16'd50;
	localparam logic [COUNT_W-1:0]    DUNK_COUNT_RST      = 3'd4;

	typedef struct packed {
		logic trigger_down;
		logic drive_mode;
		logic spin_on_request;
		logic spin_off_request;
	} ssf_in_t;

	typedef struct packed {
		logic               fire_pulse;
		logic               retract_pulse;
		logic               arm_stop_pulse;
		logic               dunk_speed_pulse;
		logic               spinners_running;
		logic [2:0]         sequence_state;
		logic [COUNT_W-1:0] shots_waiting;
	} ssf_out_t;

	typedef struct packed {
		logic [DURATION_W-1:0] spinup_ticks;
		logic [DURATION_W-1:0] dunk_wait_ticks;
		logic [DURATION_W-1:0] forward_ticks;
		logic [DURATION_W-1:0] back_ticks;
		logic [DURATION_W-1:0] drop_ticks;
		logic [COUNT_W-1:0]    dunk_count;
	} ssf_cfg_t;

endpackage

@@ src/ssf_cfg_regs.sv @@
// Configuration register file of the shot sequencer: write-only, reset to defaults.
module ssf_cfg_regs
	import ssf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output ssf_cfg_t              cfg
);

	ssf_cfg_t cfg_q;

	// decode the index, ignore writes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spinup_ticks    <= SPINUP_TICKS_RST;
			cfg_q.dunk_wait_ticks <= DUNK_WAIT_TICKS_RST;
			cfg_q.forward_ticks   <= FORWARD_TICKS_RST;
			cfg_q.back_ticks      <= BACK_TICKS_RST;
			cfg_q.drop_ticks      <= DROP_TICKS_RST;
			cfg_q.dunk_count      <= DUNK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPINUP_TICKS:    cfg_q.spinup_ticks    <= cfg_wdata;
				CFG_DUNK_WAIT_TICKS: cfg_q.dunk_wait_ticks <= cfg_wdata;
				CFG_FORWARD_TICKS:   cfg_q.forward_ticks   <= cfg_wdata;
				CFG_BACK_TICKS:      cfg_q.back_ticks      <= cfg_wdata;
				CFG_DROP_TICKS:      cfg_q.drop_ticks      <= cfg_wdata;
				CFG_DUNK_COUNT:      cfg_q.dunk_count      <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/shot_sequencer_fsm_core.sv @@
// Top level of the shot sequencer: tick handshake, sequence state machine and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid / in_ready   | in_data  (ssf_in_t), one tick
//  out     | output    | out_valid / out_ready | out_data (ssf_out_t), one result
//  cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// One tick per cycle while in_ready is high: the whole state update is one combinational pass
// from the state registers and the incoming tick into the state and result registers.
// The result is registered and appears in the cycle after its tick transfer.
// in_ready drops only while a result is held and out_ready is low.
// Reset: sequence off, timer, queue and flags cleared (prev_drive set), register defaults loaded.
`include "assert_macros.svh"

module shot_sequencer_fsm_core
	import ssf_pkg::*;
#(
	parameter int QUEUE_MAX  = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ssf_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssf_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int QW    = $clog2(QUEUE_MAX + 1);
	localparam int CMP_W = (TIMER_BITS > DURATION_W) ? TIMER_BITS : DURATION_W;
	localparam int DC_W  = (QW > COUNT_W) ? QW : COUNT_W;
	localparam logic [TIMER_BITS-1:0] TIMER_TOP = {TIMER_BITS{1'b1}};
	localparam logic [QW-1:0]         Q_MAX     = QW'(QUEUE_MAX);

	typedef enum logic [2:0] {
		ST_OFF     = 3'd0,
		ST_SPINUP  = 3'd1,
		ST_READY   = 3'd2,
		ST_FORWARD = 3'd3,
		ST_BACK    = 3'd4,
		ST_DROP    = 3'd5
	} seq_state_t;

	ssf_cfg_t cfg;

	seq_state_t            st_q, st_d;
	logic [TIMER_BITS-1:0] tmr_q, tmr_d;
	logic [QW-1:0]         q_q, q_d;
	logic                  spin_q, spin_d;
	logic                  held_q, held_d;
	logic                  prev_drive_q;
	logic                  out_valid_q;
	ssf_out_t              out_q, out_d;
	logic                  in_xfer;
	logic                  fire, retract, stop, dunk;

	ssf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// result register frees up when empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// one tick: mode, spinner requests, timer, trigger edge, then the ordered checks
	always_comb begin
		st_d    = st_q;
		tmr_d   = tmr_q;
		q_d     = q_q;
		spin_d  = spin_q;
		held_d  = held_q;
		fire    = 1'b0;
		retract = 1'b0;
		stop    = 1'b0;
		dunk    = 1'b0;

		// leaving drive mode stops the spinners
		if (prev_drive_q && !in_data.drive_mode)
			spin_d = 1'b0;

		// spinner buttons, on has priority
		if (in_data.drive_mode) begin
			if (!spin_d && in_data.spin_on_request) begin
				spin_d = 1'b1;
				q_d    = '0;
			end else if (spin_d && in_data.spin_off_request) begin
				spin_d = 1'b0;
			end
		end

		// saturating tick timer
		if (tmr_d != TIMER_TOP)
			tmr_d = tmr_d + 1'b1;

		// trigger press: queue a shot, or start a dunk burst in climb mode
		if (in_data.trigger_down) begin
			if (!held_d) begin
				held_d = 1'b1;
				if (in_data.drive_mode) begin
					if (q_d < Q_MAX)
						q_d = q_d + 1'b1;
				end else begin
					if (DC_W'(cfg.dunk_count) > DC_W'(QUEUE_MAX))
						q_d = Q_MAX;
					else
						q_d = QW'(cfg.dunk_count);
					dunk   = 1'b1;
					st_d   = ST_SPINUP;
					spin_d = 1'b1;
					tmr_d  = '0;
				end
			end
		end else begin
			held_d = 1'b0;
		end

		// fire from ready with shots queued, or from spin up after the dunk wait
		if ((st_d == ST_READY && q_d != '0 && spin_d) ||
			(st_d == ST_SPINUP && CMP_W'(tmr_d) >= CMP_W'(cfg.dunk_wait_ticks))) begin
			fire  = 1'b1;
			tmr_d = '0;
			st_d  = ST_FORWARD;
			if (q_d != '0)
				q_d = q_d - 1'b1;
		end
		if (st_d == ST_FORWARD && CMP_W'(tmr_d) >= CMP_W'(cfg.forward_ticks)) begin
			retract = 1'b1;
			st_d    = ST_BACK;
			tmr_d   = '0;
		end
		if (st_d == ST_BACK && CMP_W'(tmr_d) >= CMP_W'(cfg.back_ticks)) begin
			stop  = 1'b1;
			st_d  = ST_DROP;
			tmr_d = '0;
		end
		if (st_d == ST_DROP && CMP_W'(tmr_d) >= CMP_W'(cfg.drop_ticks))
			st_d = ST_READY;
		if (st_d == ST_OFF) begin
			if (spin_d)
				st_d = ST_SPINUP;
			else
				tmr_d = '0;
		end
		if (st_d == ST_SPINUP && CMP_W'(tmr_d) >= CMP_W'(cfg.spinup_ticks)) begin
			tmr_d = '0;
			st_d  = ST_READY;
		end
		if (st_d == ST_READY && !spin_d)
			st_d = ST_OFF;

		out_d.fire_pulse       = fire;
		out_d.retract_pulse    = retract;
		out_d.arm_stop_pulse   = stop;
		out_d.dunk_speed_pulse = dunk;
		out_d.spinners_running = spin_d;
		out_d.sequence_state   = st_d;
		out_d.shots_waiting    = COUNT_W'(q_d);
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_OFF;
			tmr_q        <= '0;
			q_q          <= '0;
			spin_q       <= 1'b0;
			held_q       <= 1'b0;
			prev_drive_q <= 1'b1;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (in_xfer) begin
				st_q         <= st_d;
				tmr_q        <= tmr_d;
				q_q          <= q_d;
				spin_q       <= spin_d;
				held_q       <= held_d;
				prev_drive_q <= in_data.drive_mode;
				out_q        <= out_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// queue never passes its limit
	`ASSERT_CLK(a_queue_limit, q_q <= Q_MAX, "shot queue above limit")
	// every tick transfer leaves a result waiting in the next cycle
	`ASSERT_NEXT(a_result_follows, in_xfer, out_valid_q, "tick transfer produced no result")
	// a dunk burst always forces the spinners on
	`ASSERT_IMPL(a_dunk_spin, out_valid_q && out_q.dunk_speed_pulse,
		out_q.spinners_running, "dunk without spinners running")
	// a held trigger never starts a second dunk
	`ASSERT_NEXT(a_dunk_edge, in_xfer && held_q && in_data.trigger_down,
		!out_q.dunk_speed_pulse, "dunk started on held trigger")

endmodule
